@@ hdl/mdu_pkg.sv @@
package mdu_pkg;

	localparam int unsigned WordWidth = 32;
	localparam int unsigned RegWidth  = 64;
	localparam int unsigned DivSteps  = 32;

	localparam logic [3:0] MODE_MADD   = 4'd0;
	localparam logic [3:0] MODE_MADDU  = 4'd1;
	localparam logic [3:0] MODE_MADD1  = 4'd2;
	localparam logic [3:0] MODE_MADDU1 = 4'd3;
	localparam logic [3:0] MODE_MULT1  = 4'd4;
	localparam logic [3:0] MODE_MULTU1 = 4'd5;
	localparam logic [3:0] MODE_DIV1   = 4'd6;
	localparam logic [3:0] MODE_DIVU1  = 4'd7;
	localparam logic [3:0] MODE_MFHI1  = 4'd8;
	localparam logic [3:0] MODE_MTHI1  = 4'd9;
	localparam logic [3:0] MODE_MFLO1  = 4'd10;
	localparam logic [3:0] MODE_MTLO1  = 4'd11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_en;
		logic div_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} status_t;

	function automatic logic is_mul_mode(input logic [3:0] mode);
		return mode inside {MODE_MADD, MODE_MADDU, MODE_MADD1, MODE_MADDU1,
			MODE_MULT1, MODE_MULTU1};
	endfunction

	function automatic logic is_div_mode(input logic [3:0] mode);
		return mode inside {MODE_DIV1, MODE_DIVU1};
	endfunction

	function automatic logic [RegWidth-1:0] sext32(input logic [WordWidth-1:0] x);
		return {{(RegWidth-WordWidth){x[WordWidth-1]}}, x};
	endfunction

endpackage

@@ hdl/mdu_ctrl.sv @@
module mdu_ctrl
	import mdu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [3:0] in_mode,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_valid,
	input  status_t    status,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (is_mul_mode(in_mode)) begin
						state_d = ST_MUL;
					end else if (is_div_mode(in_mode)) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_FIN;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// The result register is free, or its transfer happens this cycle.
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	a_commit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("result register not marked valid after commit");

	a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && !out_ready))
		else $error("commit overwrote a result that was not yet transferred");

	a_div_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && is_div_mode(in_mode)) |=> state_q == ST_DIV)
		else $error("divide did not start iterating");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && status.div_last) |=> state_q == ST_FIN)
		else $error("divide did not finish after its last step");

endmodule

@@ hdl/mdu_dpath.sv @@
module mdu_dpath
	import mdu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic [3:0]           mode,
	input  logic [RegWidth-1:0]  source_value,
	input  logic [WordWidth-1:0] second_value,
	input  logic [4:0]           dest_index,
	output logic                 write_enable,
	output logic [4:0]           write_index,
	output logic [RegWidth-1:0]  write_value,
	output logic                 divide_by_zero
);

	localparam int unsigned CntWidth = $clog2(DivSteps);

	// Architectural HI/LO pairs.
	logic [RegWidth-1:0] hi0_q, lo0_q, hi1_q, lo1_q;
	logic [RegWidth-1:0] hi0_d, lo0_d, hi1_d, lo1_d;

	// Operands captured at the input transfer.
	logic [3:0]           mode_q;
	logic [RegWidth-1:0]  rs_q;
	logic [WordWidth-1:0] rt_q;
	logic [4:0]           rd_q;

	logic [RegWidth-1:0] prod_q;

	logic [WordWidth-1:0] rem_q, quo_q, dvs_q;
	logic                 neg_a_q, neg_b_q;
	logic [CntWidth-1:0]  cnt_q;

	logic                 we_q, dz_q;
	logic [4:0]           widx_q;
	logic [RegWidth-1:0]  wval_q;

	logic                 we_d, dz_d;
	logic [4:0]           widx_d;
	logic [RegWidth-1:0]  wval_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi0_q <= '0;
			lo0_q <= '0;
			hi1_q <= '0;
			lo1_q <= '0;
		end else if (cmd.commit) begin
			hi0_q <= hi0_d;
			lo0_q <= lo0_d;
			hi1_q <= hi1_d;
			lo1_q <= lo1_d;
		end
	end

	// Restoring divide step: one quotient bit per cycle.
	logic [WordWidth:0]   div_trial, div_diff;
	logic                 div_bit;
	logic [WordWidth-1:0] div_rem_next;

	assign div_trial    = {rem_q, quo_q[WordWidth-1]};
	assign div_diff     = div_trial - {1'b0, dvs_q};
	assign div_bit      = ~div_diff[WordWidth];
	assign div_rem_next = div_bit ? div_diff[WordWidth-1:0] : div_trial[WordWidth-1:0];

	// Divider operands are loaded as magnitudes; signs are restored at the end.
	logic                 ld_signed, ld_neg_a, ld_neg_b;
	logic [WordWidth-1:0] ld_a;

	assign ld_signed = (mode == MODE_DIV1);
	assign ld_neg_a  = ld_signed & source_value[WordWidth-1];
	assign ld_neg_b  = ld_signed & second_value[WordWidth-1];
	assign ld_a      = source_value[WordWidth-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			rs_q    <= source_value;
			rt_q    <= second_value;
			rd_q    <= dest_index;
			neg_a_q <= ld_neg_a;
			neg_b_q <= ld_neg_b;
			rem_q   <= '0;
			quo_q   <= ld_neg_a ? (~ld_a + 1'b1) : ld_a;
			dvs_q   <= ld_neg_b ? (~second_value + 1'b1) : second_value;
		end else if (cmd.div_step) begin
			rem_q <= div_rem_next;
			quo_q <= {quo_q[WordWidth-2:0], div_bit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign status.div_last = (cnt_q == CntWidth'(DivSteps - 1));

	// 33x33 signed multiply covers both signed and unsigned operands.
	logic                        mul_signed;
	logic signed [WordWidth:0]   mul_a, mul_b;
	logic signed [2*WordWidth+1:0] mul_p;

	assign mul_signed = (mode_q == MODE_MADD) || (mode_q == MODE_MADD1) ||
		(mode_q == MODE_MULT1);
	assign mul_a = {mul_signed & rs_q[WordWidth-1], rs_q[WordWidth-1:0]};
	assign mul_b = {mul_signed & rt_q[WordWidth-1], rt_q};
	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_p[RegWidth-1:0];
		end
	end

	logic                 pipe1;
	logic [RegWidth-1:0]  acc, sum;
	logic [WordWidth-1:0] q_res, r_res;

	assign pipe1 = (mode_q == MODE_MADD1) || (mode_q == MODE_MADDU1);
	assign acc   = pipe1 ? {hi1_q[WordWidth-1:0], lo1_q[WordWidth-1:0]}
	                     : {hi0_q[WordWidth-1:0], lo0_q[WordWidth-1:0]};
	assign sum   = acc + prod_q;
	assign q_res = (neg_a_q ^ neg_b_q) ? (~quo_q + 1'b1) : quo_q;
	assign r_res = neg_a_q ? (~rem_q + 1'b1) : rem_q;

	always_comb begin
		hi0_d  = hi0_q;
		lo0_d  = lo0_q;
		hi1_d  = hi1_q;
		lo1_d  = lo1_q;
		we_d   = 1'b0;
		widx_d = '0;
		wval_d = '0;
		dz_d   = 1'b0;
		case (mode_q)
			MODE_MADD, MODE_MADDU: begin
				lo0_d = sext32(sum[WordWidth-1:0]);
				hi0_d = sext32(sum[RegWidth-1:WordWidth]);
				if (rd_q != '0) begin
					we_d   = 1'b1;
					widx_d = rd_q;
					wval_d = sext32(sum[WordWidth-1:0]);
				end
			end
			MODE_MADD1, MODE_MADDU1: begin
				lo1_d = sext32(sum[WordWidth-1:0]);
				hi1_d = sext32(sum[RegWidth-1:WordWidth]);
				if (rd_q != '0) begin
					we_d   = 1'b1;
					widx_d = rd_q;
					wval_d = sext32(sum[WordWidth-1:0]);
				end
			end
			MODE_MULT1, MODE_MULTU1: begin
				lo1_d = sext32(prod_q[WordWidth-1:0]);
				hi1_d = sext32(prod_q[RegWidth-1:WordWidth]);
				if (rd_q != '0) begin
					we_d   = 1'b1;
					widx_d = rd_q;
					wval_d = sext32(prod_q[WordWidth-1:0]);
				end
			end
			MODE_DIV1, MODE_DIVU1: begin
				if (rt_q == '0) begin
					dz_d = 1'b1;
				end else begin
					lo1_d = sext32(q_res);
					hi1_d = sext32(r_res);
				end
			end
			MODE_MFHI1: begin
				we_d   = 1'b1;
				widx_d = rd_q;
				wval_d = hi1_q;
			end
			MODE_MTHI1: begin
				hi1_d = rs_q;
			end
			MODE_MFLO1: begin
				we_d   = 1'b1;
				widx_d = rd_q;
				wval_d = lo1_q;
			end
			MODE_MTLO1: begin
				lo1_d = rs_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			we_q   <= we_d;
			widx_q <= widx_d;
			wval_q <= wval_d;
			dz_q   <= dz_d;
		end
	end

	assign write_enable   = we_q;
	assign write_index    = widx_q;
	assign write_value    = wval_q;
	assign divide_by_zero = dz_q;

endmodule

@@ hdl/dual_hilo_multiply_divide_unit_core.sv @@
// Dual HI/LO multiply-divide unit with two accumulator pipes.
// Input channel: in_valid/in_ready carrying mode, source_value, second_value
// and dest_index. Output channel: out_valid/out_ready carrying write_enable,
// write_index, write_value and divide_by_zero. Every input transfer yields
// exactly one result transfer, in order.
// Path from input transfer to result valid: for multiply and
// multiply-add, a registered 33x33 multiplier, then accumulate and commit;
// for divide, 32 restoring steps of one quotient bit each, then sign fix
// and commit; for moves and unused modes, commit alone. One item is
// in the datapath at a time and the next transfer is taken the cycle after
// the commit, so a new item waits until the last one commits; the divide
// iteration loop makes divide the slowest mode.
// The result sits in an output register, so a new item is taken while the
// previous result still waits. If the receiver stalls, the finished item
// holds in its final step until the output register frees up.
// Reset clears HI0/LO0/HI1/LO1 to zero, empties the output register and
// returns the controller to idle.
module dual_hilo_multiply_divide_unit_core
	import mdu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [3:0]           mode,
	input  logic [RegWidth-1:0]  source_value,
	input  logic [WordWidth-1:0] second_value,
	input  logic [4:0]           dest_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 write_enable,
	output logic [4:0]           write_index,
	output logic [RegWidth-1:0]  write_value,
	output logic                 divide_by_zero
);

	cmd_t    cmd;
	status_t status;

	mdu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_mode   (mode),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.status    (status),
		.cmd       (cmd)
	);

	mdu_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.mode           (mode),
		.source_value   (source_value),
		.second_value   (second_value),
		.dest_index     (dest_index),
		.write_enable   (write_enable),
		.write_index    (write_index),
		.write_value    (write_value),
		.divide_by_zero (divide_by_zero)
	);

endmodule
